@@ design/polyline_max_curvature_assert.svh @@
// Assertion macros shared by the curvature block.
// Each macro expects clk and arst_n in scope.
`ifndef POLYLINE_MAX_CURVATURE_ASSERT_SVH
`define POLYLINE_MAX_CURVATURE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PMC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pmc: assertion failed");

// Trigger implies condition on the following edge.
`define PMC_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("pmc: sequence assertion failed");

`endif

@@ design/pmc_pkg.sv @@
`timescale 1ns / 1ps
package pmc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int CURV_FRAC_DEF   = 16;
	localparam int CFG_W           = 21;
	localparam int CURV_W          = 32;
	// 2 * 1000 mm/m, and the bits it needs
	localparam int CURV_SCALE      = 2000;
	localparam int SCALE_W         = 11;
	localparam int QUEUE_DEPTH     = 2;

	// command passed from front to back
	typedef struct packed {
		logic curv;      // compute curvature of this triple
		logic set_err;   // first and third points lie within the threshold
		logic last;      // close the path and emit a result
		logic two_kept;  // at least two points kept so far
	} cmd_flags_t;

	localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

@@ design/pmc_fifo.sv @@
`timescale 1ns / 1ps
module pmc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = pmc_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	import pmc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/pmc_mul.sv @@
`timescale 1ns / 1ps
module pmc_mul #(
	parameter int AW = 64,
	parameter int BW = 32,
	parameter int NB = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	input  logic [NB-1:0] nbits,
	output logic          done,
	output logic [AW-1:0] prod
);
	import pmc_pkg::*;

	// shift-add, one multiplier bit per cycle, LSB first
	logic [AW-1:0] acc_q;
	logic [AW-1:0] sh_q;
	logic [BW-1:0] mb_q;
	logic [NB-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == NB'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NB'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			sh_q  <= a;
			mb_q  <= b;
		end else if (run_q) begin
			if (mb_q[0]) begin
				acc_q <= acc_q + sh_q;
			end
			sh_q <= sh_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

endmodule

@@ design/pmc_front.sv @@
`timescale 1ns / 1ps
module pmc_front #(
	parameter int CW = pmc_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [CW-1:0]     x_coord,
	input  logic signed [CW-1:0]     y_coord,
	input  logic                     is_last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [pmc_pkg::CFG_W-1:0] cfg_data,
	output logic                     cmd_push,
	input  logic                     cmd_full,
	output pmc_pkg::cmd_flags_t      cmd_flags,
	output logic [CW:0]              cmd_dxab,
	output logic [CW:0]              cmd_dyab,
	output logic [CW:0]              cmd_dxac,
	output logic [CW:0]              cmd_dyac,
	output logic [2*CW+2:0]          cmd_ab2,
	output logic [2*CW+2:0]          cmd_bc2,
	output logic [2*CW+2:0]          cmd_ac2
);
	import pmc_pkg::*;

	localparam int DW  = CW + 1;
	localparam int D2W = 2 * DW + 1;

	localparam logic [1:0] KEPT_NONE = 2'd0;
	localparam logic [1:0] KEPT_ONE  = 2'd1;
	localparam logic [1:0] KEPT_TWO  = 2'd2;

	typedef enum logic [1:0] {F_IDLE, F_BC, F_AC, F_DEC} fstate_t;

	fstate_t        state_q;
	logic [CFG_W-1:0] thr_q;
	logic [CW-1:0]  px_q, py_q;
	logic           last_q;
	logic [CW-1:0]  older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [1:0]     kept_q;
	logic [DW-1:0]  ab_dx_q, ab_dy_q;
	logic [D2W-1:0] ab2_q;
	logic [DW-1:0]  bdx_q, bdy_q, adx_q, ady_q;
	logic [2*DW-1:0] sqx_q, sqy_q;
	logic [D2W-1:0] bc2_q;

	logic [CW-1:0]   ref_x, ref_y;
	logic [DW-1:0]   diff_x, diff_y, mag_x, mag_y;
	logic [2*DW-1:0] sq_x, sq_y;
	logic [D2W-1:0]  d2, thr_ext;
	logic            drop, two, need, advance;
	cmd_flags_t      flags;

	assign cfg_ready = 1'b1;
	assign full      = (state_q != F_IDLE);

	// bc pass measures against the newer point, ac pass against the older one
	assign ref_x  = (state_q == F_BC) ? newer_x_q : older_x_q;
	assign ref_y  = (state_q == F_BC) ? newer_y_q : older_y_q;
	assign diff_x = {px_q[CW-1], px_q} - {ref_x[CW-1], ref_x};
	assign diff_y = {py_q[CW-1], py_q} - {ref_y[CW-1], ref_y};
	assign mag_x  = diff_x[DW-1] ? (~diff_x + 1'b1) : diff_x;
	assign mag_y  = diff_y[DW-1] ? (~diff_y + 1'b1) : diff_y;
	assign sq_x   = {{DW{1'b0}}, mag_x} * {{DW{1'b0}}, mag_x};
	assign sq_y   = {{DW{1'b0}}, mag_y} * {{DW{1'b0}}, mag_y};
	assign d2     = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign thr_ext = D2W'(thr_q);

	always_comb begin
		two            = (kept_q == KEPT_TWO);
		drop           = (kept_q != KEPT_NONE) && (bc2_q <= thr_ext);
		flags.curv     = two && !drop && (d2 > thr_ext);
		flags.set_err  = two && !drop && (d2 <= thr_ext);
		flags.last     = last_q;
		flags.two_kept = two || ((kept_q == KEPT_ONE) && !drop);
		need           = flags.curv || flags.set_err || flags.last;
		advance        = (state_q == F_DEC) && !(need && cmd_full);
	end

	assign cmd_push  = (state_q == F_DEC) && need && !cmd_full;
	assign cmd_flags = flags;
	assign cmd_dxab  = ab_dx_q;
	assign cmd_dyab  = ab_dy_q;
	assign cmd_dxac  = adx_q;
	assign cmd_dyac  = ady_q;
	assign cmd_ab2   = ab2_q;
	assign cmd_bc2   = bc2_q;
	assign cmd_ac2   = d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			thr_q   <= '0;
			kept_q  <= KEPT_NONE;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_BC;
					end
				end
				F_BC: state_q <= F_AC;
				F_AC: state_q <= F_DEC;
				F_DEC: begin
					if (advance) begin
						state_q <= F_IDLE;
						if (last_q) begin
							kept_q <= KEPT_NONE;
						end else if (!drop && !two) begin
							kept_q <= kept_q + 1'b1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push) begin
					px_q   <= x_coord;
					py_q   <= y_coord;
					last_q <= is_last;
				end
			end
			F_BC: begin
				bdx_q <= diff_x;
				bdy_q <= diff_y;
				sqx_q <= sq_x;
				sqy_q <= sq_y;
			end
			F_AC: begin
				bc2_q <= d2;
				adx_q <= diff_x;
				ady_q <= diff_y;
				sqx_q <= sq_x;
				sqy_q <= sq_y;
			end
			F_DEC: begin
				if (advance && !drop) begin
					older_x_q <= newer_x_q;
					older_y_q <= newer_y_q;
					newer_x_q <= px_q;
					newer_y_q <= py_q;
					ab_dx_q   <= bdx_q;
					ab_dy_q   <= bdy_q;
					ab2_q     <= bc2_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/pmc_back.sv @@
`timescale 1ns / 1ps
`include "polyline_max_curvature_assert.svh"
module pmc_back #(
	parameter int CW   = pmc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC = pmc_pkg::CURV_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_empty,
	output logic                      cmd_pop,
	input  pmc_pkg::cmd_flags_t       cmd_flags,
	input  logic [CW:0]               cmd_dxab,
	input  logic [CW:0]               cmd_dyab,
	input  logic [CW:0]               cmd_dxac,
	input  logic [CW:0]               cmd_dyac,
	input  logic [2*CW+2:0]           cmd_ab2,
	input  logic [2*CW+2:0]           cmd_bc2,
	input  logic [2*CW+2:0]           cmd_ac2,
	output logic                      empty,
	input  logic                      pop,
	output logic                      result_valid,
	output logic [pmc_pkg::CURV_W-1:0] max_curvature
);
	import pmc_pkg::*;

	localparam int DW  = CW + 1;
	localparam int D2W = 2 * DW + 1;
	localparam int KW  = SCALE_W + FRAC;
	localparam int XW  = D2W + KW;
	localparam int PW  = 3 * D2W;
	localparam int MW  = (2 * XW > PW) ? 2 * XW : PW;
	localparam int SW  = (PW + 2 * CURV_W + 2 > 2 * XW) ? PW + 2 * CURV_W + 2 : 2 * XW;
	localparam int NB  = $clog2(XW + 1);
	localparam int BIW = $clog2(CURV_W);
	localparam logic [KW-1:0] CurvScale = KW'(CURV_SCALE) << FRAC;

	typedef enum logic [3:0] {
		B_IDLE, B_M1, B_M2, B_X, B_XX, B_P1, B_P2, B_SA, B_SB, B_FIN
	} bstate_t;

	bstate_t          state_q;
	cmd_flags_t       flags_q;
	logic [DW-1:0]    dxab_q, dyab_q, dxac_q, dyac_q;
	logic [D2W-1:0]   ab2_q, bc2_q, ac2_q;
	logic [2*DW-1:0]  m1_q;
	logic [D2W-1:0]   cr_q;
	logic [XW-1:0]    x_q;
	logic [PW-1:0]    p_q;
	logic [SW-1:0]    r_q, u_q, v_q, d_q;
	logic [CURV_W-1:0] q_q, max_q, res_q;
	logic [BIW-1:0]   bit_q;
	logic             err_q, start_q, out_full_q, res_valid_q;

	logic [MW-1:0]    mul_a, mul_prod;
	logic [XW-1:0]    mul_b;
	logic [NB-1:0]    mul_n;
	logic             mul_done;
	logic [2*DW-1:0]  m2;
	logic [D2W-1:0]   cr;
	logic             t1, t2;
	logic [CURV_W-1:0] max_eff;
	logic             err_eff, ok, can_out;
	logic             in_mul;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] d);
		return d[DW-1] ? (~d + 1'b1) : d;
	endfunction

	pmc_mul #(.AW(MW), .BW(XW), .NB(NB)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.a     (mul_a),
		.b     (mul_b),
		.nbits (mul_n),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_n = '0;
		case (state_q)
			B_M1: begin
				mul_a = MW'(mag(dxab_q));
				mul_b = XW'(mag(dyac_q));
				mul_n = NB'(DW);
			end
			B_M2: begin
				mul_a = MW'(mag(dyab_q));
				mul_b = XW'(mag(dxac_q));
				mul_n = NB'(DW);
			end
			B_X: begin
				mul_a = MW'(cr_q);
				mul_b = XW'(CurvScale);
				mul_n = NB'(KW);
			end
			B_XX: begin
				mul_a = MW'(x_q);
				mul_b = x_q;
				mul_n = NB'(XW);
			end
			B_P1: begin
				mul_a = MW'(ab2_q);
				mul_b = XW'(bc2_q);
				mul_n = NB'(D2W);
			end
			B_P2: begin
				mul_a = MW'(p_q);
				mul_b = XW'(ac2_q);
				mul_n = NB'(D2W);
			end
			default: ;
		endcase
	end

	// |cross| from the two term magnitudes and their signs
	assign m2 = mul_prod[2*DW-1:0];
	assign t1 = dxab_q[DW-1] ^ dyac_q[DW-1];
	assign t2 = dyab_q[DW-1] ^ dxac_q[DW-1];
	always_comb begin
		if (t1 != t2) begin
			cr = {1'b0, m1_q} + {1'b0, m2};
		end else if (m1_q >= m2) begin
			cr = {1'b0, m1_q - m2};
		end else begin
			cr = {1'b0, m2 - m1_q};
		end
	end

	assign max_eff = (flags_q.curv && (q_q > max_q)) ? q_q : max_q;
	assign err_eff = err_q || flags_q.set_err;
	assign ok      = flags_q.two_kept && !err_eff;
	assign can_out = !out_full_q || pop;
	assign cmd_pop = (state_q == B_IDLE) && !cmd_empty;
	assign in_mul  = (state_q == B_M1) || (state_q == B_M2) || (state_q == B_X) ||
		(state_q == B_XX) || (state_q == B_P1) || (state_q == B_P2);

	assign empty         = !out_full_q;
	assign result_valid  = res_valid_q;
	assign max_curvature = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			start_q     <= 1'b0;
			out_full_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			max_q       <= '0;
			err_q       <= 1'b0;
			flags_q     <= '0;
		end else begin
			start_q <= 1'b0;
			// a result written in B_FIN on the same edge keeps the slot full
			if (pop && out_full_q && !(state_q == B_FIN && flags_q.last)) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						flags_q <= cmd_flags;
						if (cmd_flags.curv) begin
							state_q <= B_M1;
							start_q <= 1'b1;
						end else begin
							state_q <= B_FIN;
						end
					end
				end
				B_M1: begin
					if (mul_done) begin
						state_q <= B_M2;
						start_q <= 1'b1;
					end
				end
				B_M2: begin
					if (mul_done) begin
						state_q <= B_X;
						start_q <= 1'b1;
					end
				end
				B_X: begin
					if (mul_done) begin
						state_q <= B_XX;
						start_q <= 1'b1;
					end
				end
				B_XX: begin
					if (mul_done) begin
						state_q <= B_P1;
						start_q <= 1'b1;
					end
				end
				B_P1: begin
					if (mul_done) begin
						state_q <= B_P2;
						start_q <= 1'b1;
					end
				end
				B_P2: begin
					if (mul_done) begin
						state_q <= B_SA;
					end
				end
				B_SA: state_q <= B_SB;
				B_SB: begin
					state_q <= (bit_q == '0) ? B_FIN : B_SA;
				end
				B_FIN: begin
					if (!flags_q.last) begin
						max_q   <= max_eff;
						err_q   <= err_eff;
						state_q <= B_IDLE;
					end else if (can_out) begin
						out_full_q  <= 1'b1;
						res_valid_q <= ok;
						res_q       <= ok ? max_eff : '0;
						max_q       <= '0;
						err_q       <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath: products, then bitwise root search on q^2 * P <= X^2
	// with U = (q*P) << (b+1), V = P << 2b, R = X^2 - q^2 * P
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				dxab_q <= cmd_dxab;
				dyab_q <= cmd_dyab;
				dxac_q <= cmd_dxac;
				dyac_q <= cmd_dyac;
				ab2_q  <= cmd_ab2;
				bc2_q  <= cmd_bc2;
				ac2_q  <= cmd_ac2;
			end
			B_M1: if (mul_done) m1_q <= mul_prod[2*DW-1:0];
			B_M2: if (mul_done) cr_q <= cr;
			B_X:  if (mul_done) x_q <= mul_prod[XW-1:0];
			B_XX: if (mul_done) r_q <= SW'(mul_prod);
			B_P1: if (mul_done) p_q <= mul_prod[PW-1:0];
			B_P2: begin
				if (mul_done) begin
					p_q   <= mul_prod[PW-1:0];
					u_q   <= '0;
					v_q   <= SW'(mul_prod[PW-1:0]) << (2 * (CURV_W - 1));
					q_q   <= '0;
					bit_q <= BIW'(CURV_W - 1);
				end
			end
			B_SA: d_q <= u_q + v_q;
			B_SB: begin
				if (d_q <= r_q) begin
					r_q        <= r_q - d_q;
					u_q        <= (u_q >> 1) + v_q;
					q_q[bit_q] <= 1'b1;
				end else begin
					u_q <= u_q >> 1;
				end
				v_q   <= v_q >> 2;
				bit_q <= bit_q - 1'b1;
			end
			default: ;
		endcase
	end

	`PMC_ASSERT(a_mul_done_in_mul_state, !mul_done || in_mul)
	`PMC_ASSERT(a_pop_only_nonempty, !cmd_pop || !cmd_empty)
	`PMC_ASSERT(a_invalid_reads_zero, !out_full_q || res_valid_q || res_q == '0)
	`PMC_ASSERT_NEXT(a_result_written_at_fin, !out_full_q && state_q != B_FIN, !out_full_q)

endmodule

@@ design/polyline_max_curvature.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// points    in         push / full            x_coord, y_coord, is_last
// results   out        pop / empty            result_valid, max_curvature
// config    in         cfg_valid / cfg_ready  cfg_data (min_segment_sq)
//
// Front stage takes one point at a time and shows full until done with it
// (latch, two squared-distance passes on a pair of parallel multipliers,
// keep/drop decision). Back stage: a non-curvature transaction goes from
// idle straight to the finish state; a curvature triple runs six products
// on a shift-add multiplier plus a bitwise root search.
// A two-entry queue between front and back lets the front run ahead; the
// front shows full while busy or when the queue is full at its decision.
// Asynchronous active-low reset clears path state and the threshold register.
module polyline_max_curvature #(
	parameter int COORD_WIDTH    = pmc_pkg::COORD_WIDTH_DEF,
	parameter int CURV_FRAC_BITS = pmc_pkg::CURV_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic                        is_last,
	output logic                        empty,
	input  logic                        pop,
	output logic                        result_valid,
	output logic [pmc_pkg::CURV_W-1:0]  max_curvature,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pmc_pkg::CFG_W-1:0]   cfg_data
);
	import pmc_pkg::*;

	localparam int DW  = COORD_WIDTH + 1;
	localparam int D2W = 2 * DW + 1;
	// queue entry: flags, four coordinate deltas, three squared distances
	localparam int QW  = FLAGS_W + 4 * DW + 3 * D2W;

	cmd_flags_t     f_flags, b_flags;
	logic [DW-1:0]  f_dxab, f_dyab, f_dxac, f_dyac;
	logic [DW-1:0]  b_dxab, b_dyab, b_dxac, b_dyac;
	logic [D2W-1:0] f_ab2, f_bc2, f_ac2;
	logic [D2W-1:0] b_ab2, b_bc2, b_ac2;
	logic           q_push, q_full, q_pop, q_empty;
	logic [QW-1:0]  q_wdata, q_rdata;

	pmc_front #(.CW(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.x_coord  (x_coord),
		.y_coord  (y_coord),
		.is_last  (is_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd_push (q_push),
		.cmd_full (q_full),
		.cmd_flags(f_flags),
		.cmd_dxab (f_dxab),
		.cmd_dyab (f_dyab),
		.cmd_dxac (f_dxac),
		.cmd_dyac (f_dyac),
		.cmd_ab2  (f_ab2),
		.cmd_bc2  (f_bc2),
		.cmd_ac2  (f_ac2)
	);

	assign q_wdata = {f_flags, f_dxab, f_dyab, f_dxac, f_dyac, f_ab2, f_bc2, f_ac2};
	assign {b_flags, b_dxab, b_dyab, b_dxac, b_dyac, b_ab2, b_bc2, b_ac2} = q_rdata;

	pmc_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	pmc_back #(.CW(COORD_WIDTH), .FRAC(CURV_FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (q_empty),
		.cmd_pop      (q_pop),
		.cmd_flags    (b_flags),
		.cmd_dxab     (b_dxab),
		.cmd_dyab     (b_dyab),
		.cmd_dxac     (b_dxac),
		.cmd_dyac     (b_dyac),
		.cmd_ab2      (b_ab2),
		.cmd_bc2      (b_bc2),
		.cmd_ac2      (b_ac2),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.max_curvature(max_curvature)
	);

endmodule
